// File: rtl/core/lir_pkg.sv
// shared constants, types and codes of the linear interpolation resampler
package lir_pkg;

  // sample and phase formats
  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS     = 16;
  localparam int PHASE_BITS    = FRAC_BITS + 3;
  localparam int GAIN_BITS     = 16;
  localparam int GAIN_FRAC     = 14;
  localparam int MAX_OUT       = 16;
  localparam int CNT_BITS      = $clog2(MAX_OUT + 1);

  // output queue
  localparam int OUT_DEPTH     = 8;
  localparam int PTR_BITS      = $clog2(OUT_DEPTH);
  localparam int FILL_BITS     = PTR_BITS + 1;

  // configuration port
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = PHASE_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;

  localparam phase_t PHASE_ONE  = PHASE_BITS'(1) << FRAC_BITS;
  localparam phase_t PHASE_MAX  = {PHASE_BITS{1'b1}};
  localparam gain_t  GAIN_RESET = GAIN_BITS'(1) << GAIN_FRAC;

  // ratio counts as unity when 1000 * |ratio - 1.0| < 1.0
  localparam phase_t BYPASS_DEV_MAX = PHASE_BITS'(((1 << FRAC_BITS) - 1) / 1000);

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PITCH_RATIO = 1'b0,
    REG_GAIN        = 1'b1
  } lir_reg_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } lir_state_e;

  // control tag that travels beside the lane pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } lir_tag_t;

  // one result item
  typedef struct packed {
    sample_t out_left;
    sample_t out_right;
    logic    last;
  } lir_res_t;

endpackage

// File: rtl/core/lir_in_if.sv
// input item channel: one stereo source sample
interface lir_in_if;
  logic             valid;
  logic             ready;
  lir_pkg::sample_t in_left;
  lir_pkg::sample_t in_right;

  modport source (output valid, output in_left, output in_right, input ready);
  modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

// File: rtl/core/lir_out_if.sv
// output item channel: one gained stereo sample and its last flag
interface lir_out_if;
  logic             valid;
  logic             ready;
  lir_pkg::sample_t out_left;
  lir_pkg::sample_t out_right;
  logic             last;

  modport source (output valid, output out_left, output out_right, output last, input ready);
  modport sink   (input valid, input out_left, input out_right, input last, output ready);
endinterface

// File: rtl/core/lir_lane.sv
// one channel lane: interpolate between taps, apply gain, saturate
module lir_lane (
  input  logic                                clk_i,
  input  lir_pkg::sample_t                    prev_i,
  input  lir_pkg::sample_t                    cur_i,
  input  logic [lir_pkg::FRAC_BITS-1:0]       phase_i,
  input  lir_pkg::gain_t                      gain_i,
  output lir_pkg::sample_t                    res_o
);

  localparam int SW      = lir_pkg::SAMPLE_BITS;
  localparam int FB      = lir_pkg::FRAC_BITS;
  localparam int DIFF_W  = SW + 1;
  localparam int PROD_W  = DIFF_W + FB + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int GPROD_W = SW + lir_pkg::GAIN_BITS + 1;
  localparam int RND_W   = GPROD_W + 1;
  localparam int Y_W     = RND_W - lir_pkg::GAIN_FRAC;

  localparam logic [SUM_W-1:0] INTERP_HALF = SUM_W'(1) << (FB - 1);
  localparam logic [RND_W-1:0] GAIN_HALF   = RND_W'(1) << (lir_pkg::GAIN_FRAC - 1);
  localparam lir_pkg::sample_t SAT_MAX     = {1'b0, {(SW-1){1'b1}}};
  localparam lir_pkg::sample_t SAT_MIN     = {1'b1, {(SW-1){1'b0}}};

  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod_a_d, prod_a_q;
  lir_pkg::sample_t          prev_a_q;
  logic [SUM_W-1:0]          base, sum;
  lir_pkg::sample_t          interp_b_d, interp_b_q;
  logic signed [GPROD_W-1:0] gprod_c_d, gprod_c_q;
  logic [RND_W-1:0]          rnd;
  logic [Y_W-1:0]            y;
  logic [Y_W-SW:0]           y_top;
  logic                      fits;

  // stage a: difference times phase
  assign diff     = {cur_i[SW-1], cur_i} - {prev_i[SW-1], prev_i};
  assign prod_a_d = diff * $signed({1'b0, phase_i});

  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prev_a_q <= prev_i;
  end

  // stage b: add scaled previous tap, round half up, drop fraction
  assign base = {{(SUM_W-SW-FB){prev_a_q[SW-1]}}, prev_a_q, {FB{1'b0}}};
  assign sum  = base + {prod_a_q[PROD_W-1], prod_a_q} + INTERP_HALF;
  assign interp_b_d = sum[FB +: SW];

  always_ff @(posedge clk_i) begin
    interp_b_q <= interp_b_d;
  end

  // stage c: gain product
  assign gprod_c_d = interp_b_q * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    gprod_c_q <= gprod_c_d;
  end

  // round, floor shift and saturate to the sample range
  assign rnd   = {gprod_c_q[GPROD_W-1], gprod_c_q} + GAIN_HALF;
  assign y     = rnd[RND_W-1:lir_pkg::GAIN_FRAC];
  assign y_top = y[Y_W-1:SW-1];
  assign fits  = (&y_top) | ~(|y_top);
  assign res_o = fits ? y[SW-1:0] : (y[Y_W-1] ? SAT_MIN : SAT_MAX);

endmodule

// File: rtl/core/lir_merge.sv
// merges both lane results with the last flag into the output item queue
module lir_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lir_pkg::lir_tag_t               tag_i,
  input  lir_pkg::sample_t                left_i,
  input  lir_pkg::sample_t                right_i,
  output logic [lir_pkg::FILL_BITS-1:0]   fill_o,
  lir_out_if.source                       out_o
);

  lir_pkg::lir_res_t                  mem_q [lir_pkg::OUT_DEPTH];
  logic [lir_pkg::PTR_BITS-1:0]       wr_ptr_q, rd_ptr_q;
  logic [lir_pkg::FILL_BITS-1:0]      fill_q;
  logic                               push, pop;
  lir_pkg::lir_res_t                  head;

  assign push = tag_i.valid;
  assign pop  = out_o.valid & out_o.ready;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{out_left: left_i, out_right: right_i, last: tag_i.last};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  // head of queue drives the output channel
  assign head            = mem_q[rd_ptr_q];
  assign out_o.valid     = (fill_q != '0);
  assign out_o.out_left  = head.out_left;
  assign out_o.out_right = head.out_right;
  assign out_o.last      = head.last;
  assign fill_o          = fill_q;

endmodule

// File: rtl/core/linear_interp_resampler.sv
// top level: phase sequencer, configuration registers, two lanes and output merge
//
// Stereo linear interpolation resampler. Each input item is one source sample;
// it produces between zero and sixteen output items, one per phase step below
// one, plus exactly one output in bypass mode (ratio within 0.001 of unity,
// input times gain). For each item the phase accumulator issues one output per
// cycle to the two channel lanes while the queue has room; the sequencer takes
// no new input until it is through with the current item. Each issued output
// passes through a three-stage lane pipeline and an eight-entry output queue
// to the output port; the sequencer pauses when the queue and pipeline together
// could not hold another output. The first input after reset that is not in
// bypass mode loads both taps. The user must write pitch_ratio and gain
// through the configuration port only while the block is idle; the block does not enforce it.
module linear_interp_resampler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  lir_in_if.sink                               in_i,
  lir_out_if.source                            out_o,
  input  logic                                 cfg_we_i,
  input  logic [lir_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [lir_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);

  localparam int FB = lir_pkg::FRAC_BITS;
  localparam int PB = lir_pkg::PHASE_BITS;

  lir_pkg::lir_state_e            state_q, state_d;
  lir_pkg::phase_t                phase_q, phase_d;
  lir_pkg::phase_t                pitch_q;
  lir_pkg::gain_t                 gain_q;
  logic                           bypass_q;
  logic                           primed_q, primed_d;
  logic                           byp_mode_q, byp_mode_d;
  logic [lir_pkg::CNT_BITS-1:0]   cnt_q, cnt_d;
  lir_pkg::sample_t               prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  lir_pkg::sample_t               cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  lir_pkg::sample_t               byp_l_q, byp_l_d, byp_r_q, byp_r_d;
  lir_pkg::lir_tag_t              tag_a_q, tag_b_q, tag_c_q, tag_issue;

  logic                           accept, run_more, credit, issue, issue_last;
  logic [PB:0]                    phase_sum;
  lir_pkg::phase_t                phase_adv, phase_drop, cfg_dev;
  logic [lir_pkg::FILL_BITS-1:0]  fill;
  logic [lir_pkg::FILL_BITS:0]    outstanding;
  lir_pkg::sample_t               lane_prev_l, lane_cur_l, lane_prev_r, lane_cur_r;
  logic [FB-1:0]                  lane_phase;
  lir_pkg::sample_t               res_l, res_r;

  // configuration registers, bypass decided when the ratio is written
  assign cfg_dev = (cfg_data_i > lir_pkg::PHASE_ONE) ? cfg_data_i - lir_pkg::PHASE_ONE
                                                      : lir_pkg::PHASE_ONE - cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q  <= lir_pkg::PHASE_ONE;
      gain_q   <= lir_pkg::GAIN_RESET;
      bypass_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (lir_pkg::lir_reg_e'(cfg_idx_i))
        lir_pkg::REG_PITCH_RATIO: begin
          pitch_q  <= cfg_data_i;
          bypass_q <= (cfg_dev <= lir_pkg::BYPASS_DEV_MAX);
        end
        lir_pkg::REG_GAIN: begin
          gain_q <= cfg_data_i[lir_pkg::GAIN_BITS-1:0];
        end
        default: begin
          gain_q <= gain_q;
        end
      endcase
    end
  end

  // handshake and issue control
  assign in_i.ready  = (state_q == lir_pkg::ST_IDLE);
  assign accept      = in_i.valid & in_i.ready;
  assign outstanding = {1'b0, fill} + (lir_pkg::FILL_BITS + 1)'(tag_a_q.valid)
                     + (lir_pkg::FILL_BITS + 1)'(tag_b_q.valid)
                     + (lir_pkg::FILL_BITS + 1)'(tag_c_q.valid);
  assign credit      = outstanding < (lir_pkg::FILL_BITS + 1)'(lir_pkg::OUT_DEPTH);
  assign run_more    = byp_mode_q ? (cnt_q == '0)
                                  : ((phase_q < lir_pkg::PHASE_ONE)
                                     && (cnt_q < lir_pkg::CNT_BITS'(lir_pkg::MAX_OUT)));
  assign issue       = (state_q == lir_pkg::ST_RUN) & run_more & credit;

  // phase advance with saturation, and drop by one on a new sample
  assign phase_sum  = {1'b0, phase_q} + {1'b0, pitch_q};
  assign phase_adv  = phase_sum[PB] ? lir_pkg::PHASE_MAX : phase_sum[PB-1:0];
  assign phase_drop = (phase_q >= lir_pkg::PHASE_ONE) ? phase_q - lir_pkg::PHASE_ONE : '0;
  assign issue_last = byp_mode_q | (phase_adv >= lir_pkg::PHASE_ONE)
                    | (cnt_q == lir_pkg::CNT_BITS'(lir_pkg::MAX_OUT - 1));

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    primed_d   = primed_q;
    byp_mode_d = byp_mode_q;
    cnt_d      = cnt_q;
    prev_l_d   = prev_l_q;
    prev_r_d   = prev_r_q;
    cur_l_d    = cur_l_q;
    cur_r_d    = cur_r_q;
    byp_l_d    = byp_l_q;
    byp_r_d    = byp_r_q;
    case (state_q)
      lir_pkg::ST_IDLE: begin
        if (accept) begin
          state_d    = lir_pkg::ST_RUN;
          cnt_d      = '0;
          byp_mode_d = bypass_q;
          if (bypass_q) begin
            byp_l_d = in_i.in_left;
            byp_r_d = in_i.in_right;
          end else if (!primed_q) begin
            prev_l_d = in_i.in_left;
            prev_r_d = in_i.in_right;
            cur_l_d  = in_i.in_left;
            cur_r_d  = in_i.in_right;
            primed_d = 1'b1;
          end else begin
            prev_l_d = cur_l_q;
            prev_r_d = cur_r_q;
            cur_l_d  = in_i.in_left;
            cur_r_d  = in_i.in_right;
            phase_d  = phase_drop;
          end
        end
      end
      lir_pkg::ST_RUN: begin
        if (!run_more) begin
          state_d = lir_pkg::ST_IDLE;
        end else if (issue) begin
          cnt_d = cnt_q + 1'b1;
          if (!byp_mode_q) begin
            phase_d = phase_adv;
          end
        end
      end
      default: begin
        state_d = lir_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lir_pkg::ST_IDLE;
      phase_q    <= '0;
      primed_q   <= 1'b0;
      byp_mode_q <= 1'b0;
      cnt_q      <= '0;
      prev_l_q   <= '0;
      prev_r_q   <= '0;
      cur_l_q    <= '0;
      cur_r_q    <= '0;
      tag_a_q    <= '0;
      tag_b_q    <= '0;
      tag_c_q    <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      primed_q   <= primed_d;
      byp_mode_q <= byp_mode_d;
      cnt_q      <= cnt_d;
      prev_l_q   <= prev_l_d;
      prev_r_q   <= prev_r_d;
      cur_l_q    <= cur_l_d;
      cur_r_q    <= cur_r_d;
      tag_a_q    <= tag_issue;
      tag_b_q    <= tag_a_q;
      tag_c_q    <= tag_b_q;
    end
  end

  // bypass sample holds payload only
  always_ff @(posedge clk_i) begin
    byp_l_q <= byp_l_d;
    byp_r_q <= byp_r_d;
  end

  assign tag_issue = '{valid: issue, last: issue_last};

  // lane operands: bypass runs as a zero-phase interpolation of the input
  assign lane_prev_l = byp_mode_q ? byp_l_q : prev_l_q;
  assign lane_cur_l  = byp_mode_q ? byp_l_q : cur_l_q;
  assign lane_prev_r = byp_mode_q ? byp_r_q : prev_r_q;
  assign lane_cur_r  = byp_mode_q ? byp_r_q : cur_r_q;
  assign lane_phase  = byp_mode_q ? '0 : phase_q[FB-1:0];

  // channel lanes
  lir_lane u_lane_left (
    .clk_i   (clk_i),
    .prev_i  (lane_prev_l),
    .cur_i   (lane_cur_l),
    .phase_i (lane_phase),
    .gain_i  (gain_q),
    .res_o   (res_l)
  );

  lir_lane u_lane_right (
    .clk_i   (clk_i),
    .prev_i  (lane_prev_r),
    .cur_i   (lane_cur_r),
    .phase_i (lane_phase),
    .gain_i  (gain_q),
    .res_o   (res_r)
  );

  // result merge and output queue
  lir_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag_c_q),
    .left_i  (res_l),
    .right_i (res_r),
    .fill_o  (fill),
    .out_o   (out_o)
  );

endmodule

// File: verif/linear_interp_resampler_tb.sv
// self-checking testbench for the stereo linear interpolation resampler
`timescale 1ns / 100ps

module linear_interp_resampler_tb;

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     SETTLE_CYCLES  = lir_pkg::MAX_OUT + 10;
  localparam longint ONE_L          = longint'(1) <<< lir_pkg::FRAC_BITS;
  localparam longint SAMPLE_HI      = (longint'(1) <<< (lir_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO      = -SAMPLE_HI - 1;
  localparam lir_pkg::sample_t S_MAX = lir_pkg::sample_t'(SAMPLE_HI);
  localparam lir_pkg::sample_t S_MIN = lir_pkg::sample_t'(SAMPLE_LO);

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lir_pkg::CFG_IDX_BITS-1:0]  cfg_idx;
  logic [lir_pkg::CFG_DATA_BITS-1:0] cfg_data;

  lir_in_if  in_if ();
  lir_out_if out_if ();

  linear_interp_resampler uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // shadow copy of the block's registers and state
  lir_pkg::phase_t  ratio_reg;
  lir_pkg::gain_t   gain_reg;
  lir_pkg::phase_t  phase_acc_m;
  lir_pkg::sample_t prev_l_m, prev_r_m, cur_l_m, cur_r_m;
  bit               primed_m;

  lir_pkg::lir_res_t pending_out[$];

  int  fail_count   = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  settings_cnt = 0;
  int  quiet_cycles = 0;
  int  stall_left   = 0;
  bit  idle_on      = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gain in Q2.14 with rounding, floor and saturation
  function automatic lir_pkg::sample_t scale_sat(longint x);
    longint y;
    y = (x * longint'(gain_reg) + (longint'(1) <<< (lir_pkg::GAIN_FRAC - 1)))
        >>> lir_pkg::GAIN_FRAC;
    if (y > SAMPLE_HI) y = SAMPLE_HI;
    if (y < SAMPLE_LO) y = SAMPLE_LO;
    return lir_pkg::sample_t'(y);
  endfunction

  // prev + phase * (cur - prev), rounded half up
  function automatic longint lerp_tap(longint p, longint c, longint ph);
    longint v;
    v = p * ONE_L + (c - p) * ph;
    return (v + (ONE_L >>> 1)) >>> lir_pkg::FRAC_BITS;
  endfunction

  // work out every output item caused by one input item
  function automatic void predict_resample(lir_pkg::sample_t l, lir_pkg::sample_t r);
    longint            dev;
    longint            ph;
    int                n;
    lir_pkg::lir_res_t res;
    dev = (longint'(ratio_reg) > ONE_L) ? longint'(ratio_reg) - ONE_L
                                        : ONE_L - longint'(ratio_reg);
    // near-unity ratio passes the input through, scaled by the gain
    if (dev * 1000 < ONE_L) begin
      res.out_left  = scale_sat(l);
      res.out_right = scale_sat(r);
      res.last      = 1'b1;
      pending_out.push_back(res);
      return;
    end
    if (!primed_m) begin
      prev_l_m = l;
      cur_l_m  = l;
      prev_r_m = r;
      cur_r_m  = r;
      primed_m = 1'b1;
    end else begin
      prev_l_m    = cur_l_m;
      prev_r_m    = cur_r_m;
      cur_l_m     = l;
      cur_r_m     = r;
      phase_acc_m = (phase_acc_m >= lir_pkg::PHASE_ONE) ? phase_acc_m - lir_pkg::PHASE_ONE
                                                         : '0;
    end
    n  = 0;
    ph = longint'(phase_acc_m);
    while (ph < ONE_L && n < lir_pkg::MAX_OUT) begin
      res.out_left  = scale_sat(lerp_tap(prev_l_m, cur_l_m, ph));
      res.out_right = scale_sat(lerp_tap(prev_r_m, cur_r_m, ph));
      res.last      = 1'b0;
      pending_out.push_back(res);
      n++;
      ph = ph + longint'(ratio_reg);
      if (ph > longint'(lir_pkg::PHASE_MAX)) ph = longint'(lir_pkg::PHASE_MAX);
    end
    phase_acc_m = lir_pkg::phase_t'(ph);
    if (n > 0) begin
      res      = pending_out.pop_back();
      res.last = 1'b1;
      pending_out.push_back(res);
    end
  endfunction

  // send one stereo item, with an optional gap in front of it
  task automatic send_sample(input lir_pkg::sample_t l, input lir_pkg::sample_t r);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.in_left  <= l;
    in_if.in_right <= r;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_resample(l, r);
    items_sent++;
  endtask

  // hold the input until every expected item is out and the sequencer is idle
  task automatic drain_outputs();
    in_if.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers while idle
  task automatic set_config(input lir_pkg::phase_t ratio, input lir_pkg::gain_t g);
    drain_outputs();
    cfg_we   <= 1'b1;
    cfg_idx  <= lir_pkg::REG_PITCH_RATIO;
    cfg_data <= ratio;
    @(posedge clk);
    cfg_idx  <= lir_pkg::REG_GAIN;
    cfg_data <= lir_pkg::CFG_DATA_BITS'(g);
    @(posedge clk);
    cfg_we   <= 1'b0;
    ratio_reg = ratio;
    gain_reg  = g;
    settings_cnt++;
  endtask

  function automatic lir_pkg::sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return lir_pkg::sample_t'($urandom_range(0, 511)) - lir_pkg::sample_t'(256);
      default: return lir_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic lir_pkg::phase_t rand_ratio();
    case ($urandom_range(0, 9))
      0:       return lir_pkg::phase_t'(32'd65536 - $urandom_range(0, 65)
                                        + $urandom_range(0, 65));
      1:       return lir_pkg::phase_t'($urandom_range(4096, 12000));
      2:       return lir_pkg::phase_t'($urandom_range(0, 524287));
      default: return lir_pkg::phase_t'($urandom_range(4096, 262144));
    endcase
  endfunction

  // unity ratio after reset: straight pass-through, no priming
  task automatic test_bypass_extremes();
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample('0, -1);
    send_sample(-1, '0);
  endtask

  // first sample loads both taps, then full-scale swings at half rate
  task automatic test_priming_and_extremes();
    set_config(lir_pkg::phase_t'(32768), lir_pkg::gain_t'(16384));
    send_sample(lir_pkg::sample_t'(1000), lir_pkg::sample_t'(-1000));
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample(S_MAX, S_MAX);
    send_sample('0, '0);
  endtask

  // zero ratio caps each input at the output limit, full gain saturates
  task automatic test_ratio_zero();
    set_config('0, lir_pkg::gain_t'(16'hFFFF));
    send_sample(S_MAX, S_MIN);
    send_sample(lir_pkg::sample_t'(3000000), lir_pkg::sample_t'(-3000000));
  endtask

  // huge ratio saturates the phase, later inputs emit nothing
  task automatic test_phase_overflow();
    set_config(lir_pkg::PHASE_MAX, '0);
    send_sample(S_MAX, S_MIN);
    send_sample(lir_pkg::sample_t'(12345), lir_pkg::sample_t'(-54321));
    send_sample(S_MIN, S_MAX);
    set_config(lir_pkg::phase_t'(262144), lir_pkg::gain_t'(20000));
    send_sample(lir_pkg::sample_t'(777), lir_pkg::sample_t'(-777));
    send_sample(S_MAX, S_MIN);
  endtask

  // edges of the bypass window on both sides of unity
  task automatic test_bypass_edges();
    set_config(lir_pkg::PHASE_ONE + lir_pkg::phase_t'(lir_pkg::BYPASS_DEV_MAX),
               lir_pkg::gain_t'(8192));
    send_sample(S_MAX, S_MIN);
    send_sample(lir_pkg::sample_t'(-5), lir_pkg::sample_t'(5));
    set_config(lir_pkg::PHASE_ONE - lir_pkg::phase_t'(lir_pkg::BYPASS_DEV_MAX + 1),
               lir_pkg::gain_t'(16384));
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    set_config(lir_pkg::PHASE_ONE + lir_pkg::phase_t'(lir_pkg::BYPASS_DEV_MAX + 1),
               lir_pkg::gain_t'(16384));
    send_sample(lir_pkg::sample_t'(100000), lir_pkg::sample_t'(-100000));
  endtask

  // lowest and highest nominal ratio
  task automatic test_ratio_limits();
    set_config(lir_pkg::phase_t'(4096), lir_pkg::gain_t'(16384));
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    set_config(lir_pkg::phase_t'(262144), lir_pkg::gain_t'(16384));
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
  endtask

  // random items over several random settings, last stretch without idling
  task automatic test_random_settings();
    for (int seg = 0; seg < 5; seg++) begin
      if (seg == 4) begin
        set_config(rand_ratio(), lir_pkg::gain_t'(16384));
        idle_on = 1'b0;
      end else if (seg == 2) begin
        set_config(rand_ratio(), lir_pkg::gain_t'(16'hFFFF));
      end else begin
        set_config(rand_ratio(), lir_pkg::gain_t'($urandom_range(0, 65535)));
      end
      for (int k = 0; k < 16; k++) begin
        send_sample(rand_sample(), rand_sample());
        // pause the sender until all results are back
        if (k == 10) drain_outputs();
      end
    end
  endtask

  // output ready with random stall bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // compare each output item with the oldest expectation
  always @(posedge clk) begin
    lir_pkg::lir_res_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected item left=%0d right=%0d last=%0b", $time,
                 out_if.out_left, out_if.out_right, out_if.last);
        fail_count++;
      end else begin
        exp_res = pending_out.pop_front();
        if (out_if.out_left !== exp_res.out_left) begin
          $display("%0t: out_left expected %0d actual %0d", $time,
                   exp_res.out_left, out_if.out_left);
          fail_count++;
        end
        if (out_if.out_right !== exp_res.out_right) begin
          $display("%0t: out_right expected %0d actual %0d", $time,
                   exp_res.out_right, out_if.out_right);
          fail_count++;
        end
        if (out_if.last !== exp_res.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_res.last, out_if.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("linear_interp_resampler_tb: errors");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.in_left  <= '0;
    in_if.in_right <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= lir_pkg::REG_PITCH_RATIO;
    cfg_data       <= '0;
    ratio_reg   = lir_pkg::PHASE_ONE;
    gain_reg    = lir_pkg::GAIN_RESET;
    phase_acc_m = '0;
    prev_l_m    = '0;
    prev_r_m    = '0;
    cur_l_m     = '0;
    cur_r_m     = '0;
    primed_m    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bypass_extremes();
    test_priming_and_extremes();
    test_ratio_zero();
    test_phase_overflow();
    test_bypass_edges();
    test_ratio_limits();
    test_random_settings();

    drain_outputs();
    $display("covered %0d input items and %0d output items over %0d register settings,",
             items_sent, results_seen, settings_cnt);
    $display("including bypass edges, priming, zero ratio, phase saturation and full gain");
    if (fail_count == 0 && pending_out.size() == 0) begin
      $display("linear_interp_resampler_tb: clean");
    end else begin
      $display("linear_interp_resampler_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lir_pkg.sv
rtl/core/lir_in_if.sv
rtl/core/lir_out_if.sv
rtl/core/lir_lane.sv
rtl/core/lir_merge.sv
rtl/core/linear_interp_resampler.sv
verif/linear_interp_resampler_tb.sv
